>>> rtl/ourx_pkg.sv
// shared types and constants of the oversampled uart receiver
package ourx_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_RATE   = 2'd0,
        CFG_STOP   = 2'd1,
        CFG_PARITY = 2'd2,
        CFG_IDLE   = 2'd3
    } t_cfg_reg;

    localparam int CFG_IDX_W   = 2;
    localparam int RUN_W       = 14;
    localparam int FRAME_W     = 12;
    localparam int BIT_IDX_W   = 4;
    localparam int STOP_W      = 2;
    localparam int IDLE_W      = 4;
    localparam int BYTE_W      = 8;
    localparam int DATA_BITS   = 8;

    localparam logic [STOP_W-1:0]    STOP_RESET   = 2'd1;
    localparam logic                 PARITY_RESET = 1'b0;
    localparam logic [IDLE_W-1:0]    IDLE_RESET   = 4'd10;
    localparam logic [RUN_W-1:0]     RUN_MAX      = {RUN_W{1'b1}};
    localparam logic [BIT_IDX_W-1:0] FRAME_BASE   = BIT_IDX_W'(1 + DATA_BITS);

    typedef logic [BIT_IDX_W-1:0] t_bit_idx;
    typedef logic [RUN_W-1:0]     t_run;
    typedef logic [FRAME_W-1:0]   t_frame;
    typedef logic [BYTE_W-1:0]    t_byte;

endpackage

>>> rtl/ourx_if.sv
// channel interfaces: line sample, received byte, configuration write
interface ourx_rx_if;
    logic valid;
    logic ready;
    logic rx_sample;

    modport source (output valid, output rx_sample, input ready);
    modport sink   (input valid, input rx_sample, output ready);
endinterface

interface ourx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] received_byte;

    modport source (output valid, output received_byte, input ready);
    modport sink   (input valid, input received_byte, output ready);
endinterface

interface ourx_cfg_if #(
    parameter int DATA_W = 10
);
    logic              valid;
    logic              ready;
    logic [1:0]        index;
    logic [DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/ourx_cfg_regs.sv
// configuration registers and the values derived from them
module ourx_cfg_regs #(
    parameter int RATE_BITS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    ourx_cfg_if.sink                     i_cfg,
    output logic [RATE_BITS-1:0]         o_rate,
    output logic [RATE_BITS-1:0]         o_half_rate,
    output logic [ourx_pkg::BIT_IDX_W-1:0] o_frame_len,
    output logic [RATE_BITS+ourx_pkg::IDLE_W-1:0] o_idle_limit
);
    import ourx_pkg::*;

    localparam int LIMIT_W    = RATE_BITS + IDLE_W;
    localparam int RATE_RESET = 16 & ((1 << RATE_BITS) - 1);

    logic [RATE_BITS-1:0] r_rate;
    logic [STOP_W-1:0]    r_stop;
    logic                 r_parity;
    logic [IDLE_W-1:0]    r_idle;
    logic [LIMIT_W-1:0]   r_idle_limit, n_idle_limit;
    logic [RATE_BITS-1:0] r_half, n_half;
    logic [RATE_BITS:0]   rate_plus_one;
    logic                 cfg_we;

    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate   <= RATE_BITS'(RATE_RESET);
            r_stop   <= STOP_RESET;
            r_parity <= PARITY_RESET;
            r_idle   <= IDLE_RESET;
        end else if (cfg_we) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_RATE:   r_rate   <= i_cfg.data;
                CFG_STOP:   r_stop   <= i_cfg.data[STOP_W-1:0];
                CFG_PARITY: r_parity <= i_cfg.data[0];
                CFG_IDLE:   r_idle   <= i_cfg.data[IDLE_W-1:0];
                default:    r_rate   <= r_rate;
            endcase
        end
    end

    // idle threshold product and half bit period, refreshed every cycle
    assign rate_plus_one = {1'b0, r_rate} + (RATE_BITS+1)'(1);
    assign n_half        = rate_plus_one[RATE_BITS:1];
    assign n_idle_limit  = LIMIT_W'(r_idle) * LIMIT_W'(r_rate);

    always_ff @(posedge i_clk) begin
        r_idle_limit <= n_idle_limit;
        r_half       <= n_half;
    end

    assign o_rate       = r_rate;
    assign o_half_rate  = r_half;
    assign o_idle_limit = r_idle_limit;
    assign o_frame_len  = FRAME_BASE + BIT_IDX_W'(r_parity) + BIT_IDX_W'(r_stop);

endmodule

>>> rtl/ourx_bit_engine.sv
// sample register, bit timing and frame assembly, result register
module ourx_bit_engine #(
    parameter int RATE_BITS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    ourx_rx_if.sink                      i_rx,
    ourx_byte_if.source                  o_byte,
    input  logic [RATE_BITS-1:0]         i_rate,
    input  logic [RATE_BITS-1:0]         i_half_rate,
    input  logic [ourx_pkg::BIT_IDX_W-1:0] i_frame_len,
    input  logic [RATE_BITS+ourx_pkg::IDLE_W-1:0] i_idle_limit
);
    import ourx_pkg::*;

    localparam int LIMIT_W = RATE_BITS + IDLE_W;
    localparam int CMP_W   = (LIMIT_W > RUN_W) ? LIMIT_W : RUN_W;

    // input register
    logic r_in_valid;
    logic r_in_sample;
    // receiver state
    logic [RATE_BITS-1:0] r_countdown, n_countdown;
    logic                 r_sync, n_sync;
    t_run                 r_run, n_run;
    t_frame               r_frame, n_frame;
    t_bit_idx             r_idx, n_idx;
    // result register
    logic                 r_out_valid;
    t_byte                r_out_byte;

    logic                 out_free;
    logic                 advance;
    logic                 start_edge;
    logic [RATE_BITS-1:0] cd_start, cd_dec;
    logic                 sync_start, idle_hit, take_bit, frame_done;
    t_bit_idx             idx_inc;
    t_frame               frame_bits;

    assign out_free   = !r_out_valid || o_byte.ready;
    assign advance    = r_in_valid && out_free;
    assign i_rx.ready = !r_in_valid || out_free;

    // input sample register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_sample <= i_rx.rx_sample;
        end
    end

    // start edge, run length and idle detection
    always_comb begin
        start_edge = !r_sync && !r_in_sample && (r_run != '0);
        cd_start   = start_edge ? i_half_rate : r_countdown;
        sync_start = r_sync || start_edge;
        if (r_in_sample) begin
            n_run = (r_run == RUN_MAX) ? r_run : r_run + RUN_W'(1);
        end else begin
            n_run = '0;
        end
        idle_hit = CMP_W'(n_run) >= CMP_W'(i_idle_limit);
        n_sync   = sync_start && !idle_hit;
        cd_dec   = cd_start - RATE_BITS'(1);
        take_bit = n_sync && (cd_dec == '0);
    end

    // bit sampling and frame completion
    always_comb begin
        n_countdown = cd_dec;
        frame_bits  = r_frame;
        n_frame     = r_frame;
        n_idx       = r_idx;
        idx_inc     = r_idx + BIT_IDX_W'(1);
        frame_done  = 1'b0;
        if (take_bit) begin
            n_countdown = i_rate;
            if (r_idx < BIT_IDX_W'(FRAME_W)) begin
                frame_bits[r_idx] = r_frame[r_idx] | r_in_sample;
            end
            n_frame = frame_bits;
            n_idx   = idx_inc;
            if (idx_inc >= i_frame_len) begin
                frame_done = 1'b1;
                n_frame    = '0;
                n_idx      = '0;
            end
        end
    end

    // receiver state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_countdown <= '0;
            r_sync      <= 1'b0;
            r_run       <= '0;
            r_frame     <= '0;
            r_idx       <= '0;
        end else if (advance) begin
            r_countdown <= n_countdown;
            r_sync      <= n_sync;
            r_run       <= n_run;
            r_frame     <= n_frame;
            r_idx       <= n_idx;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && frame_done;
        end
    end

    // the byte includes the bit taken on this tick
    always_ff @(posedge i_clk) begin
        if (advance && frame_done) begin
            r_out_byte <= frame_bits[DATA_BITS:1];
        end
    end

    assign o_byte.valid         = r_out_valid;
    assign o_byte.received_byte = r_out_byte;

endmodule

>>> rtl/oversampled_uart_receiver_core.sv
// top level of the oversampled uart receiver (8n1 after reset, parity and stop bits configurable)
//
//  channel  | direction | payload                  | transfer when
//  i_rx     | in        | rx_sample (1 bit)        | valid && ready
//  o_byte   | out       | received_byte (8 bits)   | valid && ready
//  i_cfg    | in        | index (2), data (RATE_BITS) | valid && ready (always ready)
//
// one sample is taken per cycle while i_rx is ready; a sample goes through
// the input register, then the timing and framing logic updates state and
// may load the result register, which presents the byte on o_byte.
// i_rst_n is synchronous; reset restores the register defaults and clears sync.
// a stalled result holds the result register and the input register, and
// i_rx stays ready while the input register is empty.
module oversampled_uart_receiver_core #(
    parameter int RATE_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ourx_rx_if.sink     i_rx,
    ourx_byte_if.source o_byte,
    ourx_cfg_if.sink    i_cfg
);
    import ourx_pkg::*;

    logic [RATE_BITS-1:0]        rate;
    logic [RATE_BITS-1:0]        half_rate;
    logic [BIT_IDX_W-1:0]        frame_len;
    logic [RATE_BITS+IDLE_W-1:0] idle_limit;

    // configuration registers
    ourx_cfg_regs #(
        .RATE_BITS (RATE_BITS)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .o_rate       (rate),
        .o_half_rate  (half_rate),
        .o_frame_len  (frame_len),
        .o_idle_limit (idle_limit)
    );

    // sampling and framing
    ourx_bit_engine #(
        .RATE_BITS (RATE_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (i_rx),
        .o_byte       (o_byte),
        .i_rate       (rate),
        .i_half_rate  (half_rate),
        .i_frame_len  (frame_len),
        .i_idle_limit (idle_limit)
    );

endmodule

>>> bench/oversampled_uart_receiver_core_test.sv
// self-checking bench for the oversampled uart receiver: line samples in, bytes checked out
`timescale 1ns / 100ps

module oversampled_uart_receiver_core_test;
    import ourx_pkg::*;

    localparam int RATE_BITS      = 10;
    localparam int RATE_RESET     = 16;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 16;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_SAMPLES = 550;
    localparam int RANDOM_FRAMES  = 6;

    typedef enum logic [1:0] {
        LINE_SAMPLE,
        LINE_CFG,
        LINE_SETTLE
    } t_line_op;

    typedef struct packed {
        t_line_op             op;
        logic                 level;
        t_cfg_reg             reg_idx;
        logic [RATE_BITS-1:0] value;
        logic [4:0]           gap;
    } t_line_event;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ourx_rx_if                       rx_if ();
    ourx_byte_if                     byte_if ();
    ourx_cfg_if #(.DATA_W(RATE_BITS)) cfg_if ();

    oversampled_uart_receiver_core #(.RATE_BITS(RATE_BITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_byte  (byte_if),
        .i_cfg   (cfg_if)
    );

    // stimulus and expected bytes
    t_line_event line_events[$];
    t_byte       due_bytes[$];

    // build-time copy of the register settings, used to shape frames
    int line_rate   = RATE_RESET;
    int line_stops  = 1;
    int line_parity = 0;
    int line_idle   = 10;
    bit busy_sender;
    int samples_queued;
    int frames_queued;

    // receiver mirror: registers and state
    logic [RATE_BITS-1:0] rate_reg;
    logic [STOP_W-1:0]    stop_reg;
    logic                 parity_reg;
    logic [IDLE_W-1:0]    idle_reg;
    logic [RATE_BITS-1:0] bit_timer;
    logic                 synced;
    t_run                 high_run;
    t_frame               frame_bits;
    t_bit_idx             bit_count;

    // driver and monitor bookkeeping
    t_line_event head;
    logic        head_loaded;
    int unsigned gap_left;
    int unsigned quiet_cycles;
    int unsigned sink_hold;
    bit          sink_calm;
    int unsigned byte_count;
    int unsigned error_count;
    longint      cycle_count;
    longint      cycle_limit = 64'd10_000_000;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // one oversampling tick of the receiver; queues a byte when a frame completes
    function automatic void advance_receiver(input logic pin);
        logic [4:0] frame_len;
        if (!synced && !pin && high_run != '0) begin
            bit_timer = RATE_BITS'(({1'b0, rate_reg} + 1'b1) >> 1);
            synced    = 1'b1;
        end
        if (pin) begin
            if (high_run != RUN_MAX) high_run = high_run + 1'b1;
        end else begin
            high_run = '0;
        end
        if (32'(high_run) >= 32'(idle_reg) * 32'(rate_reg)) synced = 1'b0;
        bit_timer = bit_timer - 1'b1;
        if (synced && bit_timer == '0) begin
            bit_timer = rate_reg;
            // bits past the frame register are counted but dropped
            if (bit_count < t_bit_idx'(FRAME_W)) frame_bits[bit_count] = frame_bits[bit_count] | pin;
            bit_count = bit_count + 1'b1;
            frame_len = 5'(FRAME_BASE) + 5'(parity_reg) + 5'(stop_reg);
            if (5'(bit_count) >= frame_len) begin
                due_bytes.push_back(frame_bits[DATA_BITS:1]);
                frame_bits = '0;
                bit_count  = '0;
            end
        end
    endfunction

    task automatic push_level(input logic level, input int count);
        t_line_event ev;
        repeat (count) begin
            ev       = '0;
            ev.op    = LINE_SAMPLE;
            ev.level = level;
            ev.gap   = busy_sender ? 5'($urandom_range(0, 16)) : 5'd0;
            line_events.push_back(ev);
            samples_queued++;
        end
    endtask

    // start bit, eight data bits lsb first, optional parity, stop bits
    task automatic push_frame(input logic [7:0] data, input logic parity_bit);
        push_level(1'b0, line_rate);
        for (int i = 0; i < DATA_BITS; i++) push_level(data[i], line_rate);
        if (line_parity != 0) push_level(parity_bit, line_rate);
        push_level(1'b1, line_rate * line_stops);
        frames_queued++;
    endtask

    // enough high samples to drop sync
    task automatic push_idle();
        push_level(1'b1, line_idle * line_rate + $urandom_range(1, 4));
    endtask

    task automatic push_config(input t_cfg_reg which, input int value);
        t_line_event ev;
        ev         = '0;
        ev.op      = LINE_CFG;
        ev.reg_idx = which;
        ev.value   = RATE_BITS'(value);
        line_events.push_back(ev);
        case (which)
            CFG_RATE:   line_rate   = value;
            CFG_STOP:   line_stops  = value;
            CFG_PARITY: line_parity = value;
            default:    line_idle   = value;
        endcase
    endtask

    // hold the line until every expected byte has been taken
    task automatic push_settle();
        t_line_event ev;
        ev    = '0;
        ev.op = LINE_SETTLE;
        line_events.push_back(ev);
    endtask

    // sample and register-write driver
    always @(posedge i_clk) begin
        logic rx_next;
        logic cfg_next;
        logic settled;
        if (!i_rst_n) begin
            rx_if.valid  <= 1'b0;
            cfg_if.valid <= 1'b0;
            head_loaded  = 1'b0;
            gap_left     = 0;
            quiet_cycles = 0;
        end else begin
            rx_next  = rx_if.valid && !rx_if.ready;
            cfg_next = cfg_if.valid && !cfg_if.ready;
            if (rx_if.valid && rx_if.ready) quiet_cycles = 0;
            else if (quiet_cycles < SETTLE_CYCLES) quiet_cycles++;
            settled = quiet_cycles >= SETTLE_CYCLES && due_bytes.size() == 0;
            if (!rx_next && !cfg_next) begin
                if (!head_loaded && line_events.size() != 0) begin
                    head        = line_events.pop_front();
                    head_loaded = 1'b1;
                    gap_left    = head.gap;
                end
                if (head_loaded) begin
                    if (gap_left != 0) begin
                        gap_left--;
                    end else begin
                        case (head.op)
                            LINE_SAMPLE: begin
                                rx_next = 1'b1;
                                rx_if.rx_sample <= head.level;
                                head_loaded = 1'b0;
                            end
                            LINE_CFG: begin
                                if (settled) begin
                                    cfg_next = 1'b1;
                                    cfg_if.index <= head.reg_idx;
                                    cfg_if.data  <= head.value;
                                    head_loaded = 1'b0;
                                end
                            end
                            default: begin
                                if (settled) head_loaded = 1'b0;
                            end
                        endcase
                    end
                end
            end
            rx_if.valid  <= rx_next;
            cfg_if.valid <= cfg_next;
        end
    end

    // byte checker, mirror update and result back-pressure
    always @(posedge i_clk) begin
        t_byte want;
        if (!i_rst_n) begin
            rate_reg   = RATE_BITS'(RATE_RESET);
            stop_reg   = STOP_RESET;
            parity_reg = PARITY_RESET;
            idle_reg   = IDLE_RESET;
            bit_timer  = '0;
            synced     = 1'b0;
            high_run   = '0;
            frame_bits = '0;
            bit_count  = '0;
            sink_hold  = 0;
            sink_calm  = 1'b0;
            byte_if.ready <= 1'b0;
        end else begin
            // compare each byte transfer with the oldest expected byte
            if (byte_if.valid && byte_if.ready) begin
                if (due_bytes.size() == 0) begin
                    if (error_count < MAX_REPORTS)
                        $display("unexpected received_byte %02h", byte_if.received_byte);
                    error_count++;
                end else begin
                    want = due_bytes.pop_front();
                    if (byte_if.received_byte !== want) begin
                        if (error_count < MAX_REPORTS)
                            $display("received_byte mismatch: expected %02h, got %02h",
                                     want, byte_if.received_byte);
                        error_count++;
                    end
                end
                byte_count++;
                if (byte_count % 8 == 0) sink_calm = $urandom_range(0, 2) == 0;
                sink_hold = sink_calm ? 0 : $urandom_range(0, 16);
            end
            // register write transfer
            if (cfg_if.valid && cfg_if.ready) begin
                case (t_cfg_reg'(cfg_if.index))
                    CFG_RATE:   rate_reg   = cfg_if.data;
                    CFG_STOP:   stop_reg   = cfg_if.data[STOP_W-1:0];
                    CFG_PARITY: parity_reg = cfg_if.data[0];
                    CFG_IDLE:   idle_reg   = cfg_if.data[IDLE_W-1:0];
                    default:    ;
                endcase
            end
            // line sample transfer
            if (rx_if.valid && rx_if.ready) advance_receiver(rx_if.rx_sample);
            if (sink_hold != 0) begin
                sink_hold--;
                byte_if.ready <= 1'b0;
            end else begin
                byte_if.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= cycle_limit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int pick;
        int random_base;
        int frame_base;
        i_rst_n         = 1'b0;
        rx_if.valid     = 1'b0;
        rx_if.rx_sample = 1'b0;
        byte_if.ready   = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = '0;
        cfg_if.data     = '0;

        // reset settings: clean frames with all-zero and all-one data
        busy_sender = 1'b1;
        push_level(1'b1, 20);
        push_frame(8'h00, 1'b0);
        push_frame(8'hff, 1'b0);
        push_idle();
        push_settle();
        // fastest rate, one sample per bit
        push_config(CFG_RATE, 1);
        push_idle();
        push_frame(8'h5a, 1'b1);
        push_frame(8'h01, 1'b0);
        push_frame(8'h80, 1'b0);
        push_idle();
        // parity and two stop bits
        push_config(CFG_RATE, 3);
        push_config(CFG_PARITY, 1);
        push_config(CFG_STOP, 2);
        push_idle();
        push_frame(8'h3c, 1'b1);
        push_frame(8'hc3, 1'b0);
        push_idle();
        // three stops with parity: frame longer than the frame register
        push_config(CFG_STOP, 3);
        push_idle();
        push_frame(8'h96, 1'b1);
        push_frame(8'h69, 1'b0);
        push_idle();
        // no stop bit and no parity: nine-bit frame
        push_config(CFG_STOP, 0);
        push_config(CFG_PARITY, 0);
        push_idle();
        push_frame(8'he7, 1'b0);
        push_idle();
        // frame length cut while a frame is half collected
        push_config(CFG_STOP, 2);
        push_config(CFG_PARITY, 1);
        push_idle();
        push_level(1'b0, line_rate);
        for (int i = 0; i < DATA_BITS; i++) push_level(1'(8'h4b >> i), line_rate);
        push_level(1'b1, line_rate);
        push_config(CFG_STOP, 0);
        push_config(CFG_PARITY, 0);
        push_level(1'b1, line_rate);
        push_idle();
        // partial frame survives an idle stretch
        push_config(CFG_STOP, 1);
        push_idle();
        push_level(1'b0, line_rate);
        push_level(1'b1, line_rate);
        push_level(1'b0, line_rate);
        push_idle();
        push_frame(8'h33, 1'b0);
        push_idle();
        // zero idle periods: sync never holds
        push_config(CFG_IDLE, 0);
        push_frame(8'h55, 1'b0);
        push_frame(8'hcc, 1'b0);
        push_level(1'b1, 8);
        // zero rate: sync never holds either
        push_config(CFG_IDLE, 10);
        push_config(CFG_RATE, 0);
        push_level(1'b1, 4);
        repeat (20) push_level(1'($urandom), 1);
        // slowest rate with the longest idle setting: start edge with a long half period
        busy_sender = 1'b0;
        push_config(CFG_RATE, (1 << RATE_BITS) - 1);
        push_config(CFG_IDLE, 15);
        push_level(1'b1, 1);
        push_level(1'b0, 40);
        push_level(1'b1, 8);
        // short rate again after a stretch at the slowest rate
        push_config(CFG_RATE, 2);
        push_level(1'b0, 1);
        push_level(1'b1, 40);
        push_frame(8'hb4, 1'b0);
        push_level(1'b1, 40);

        // random phases: mostly clean frame streams with random data and settings
        random_base = samples_queued;
        frame_base  = frames_queued;
        while (samples_queued - random_base < RANDOM_SAMPLES
               || frames_queued - frame_base < RANDOM_FRAMES) begin
            busy_sender = $urandom_range(0, 2) != 0;
            pick = $urandom_range(0, 9);
            if (pick < 5) push_config(CFG_RATE, $urandom_range(1, 3));
            else if (pick < 9) push_config(CFG_RATE, $urandom_range(4, 8));
            else push_config(CFG_RATE, $urandom_range(9, 16));
            push_config(CFG_STOP, $urandom_range(0, 9) == 0 ? $urandom_range(0, 3)
                                                            : $urandom_range(1, 2));
            push_config(CFG_PARITY, $urandom_range(0, 1));
            push_config(CFG_IDLE, $urandom_range(0, 4) == 0 ? $urandom_range(1, 9)
                                                            : $urandom_range(10, 15));
            push_idle();
            repeat ($urandom_range(3, 8)) begin
                if (samples_queued - random_base >= RANDOM_SAMPLES
                    && frames_queued - frame_base >= RANDOM_FRAMES)
                    break;
                pick = $urandom_range(0, 19);
                if (pick < 13) begin
                    repeat ($urandom_range(1, 3)) push_frame(8'($urandom), 1'($urandom));
                    push_idle();
                end else if (pick < 16) begin
                    // line noise of random levels and lengths
                    repeat ($urandom_range(1, 24))
                        push_level(1'($urandom), $urandom_range(1, line_rate));
                    push_idle();
                end else if (pick < 19) begin
                    // frame cut short by idle
                    push_level(1'b0, line_rate);
                    repeat ($urandom_range(0, 7)) push_level(1'($urandom), line_rate);
                    push_idle();
                end else begin
                    push_settle();
                end
            end
        end

        // worst case per entry: sender gap, receiver stall, transfer cycles
        cycle_limit = 64'(line_events.size()) * 4 * 36 + 64'd200_000;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (line_events.size() != 0 || head_loaded || rx_if.valid || cfg_if.valid
               || due_bytes.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0 && due_bytes.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/ourx_pkg.sv
rtl/ourx_if.sv
rtl/ourx_cfg_regs.sv
rtl/ourx_bit_engine.sv
rtl/oversampled_uart_receiver_core.sv
bench/oversampled_uart_receiver_core_test.sv
